// ===== design/cobs_crc8_packet_deframer_core_assert.svh =====
// ----------------------------------------------------------------------------
// COBS CRC-8 deframer assertion macros
// Concurrent check wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef COBS_CRC8_PACKET_DEFRAMER_CORE_ASSERT_SVH
`define COBS_CRC8_PACKET_DEFRAMER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// property holds at every edge outside reset
`define CCPD_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("ccpd assertion failed");

// consequent holds in the cycle after the antecedent
`define CCPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ccpd assertion failed");

`else

`define CCPD_ASSERT(lbl, clk, rst_n, prop)
`define CCPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/ccpd_pkg.sv =====
// ----------------------------------------------------------------------------
// COBS CRC-8 deframer package
// Widths, status codes, deframer state type and the CRC-8 byte fold.
// ----------------------------------------------------------------------------
package ccpd_pkg;

	localparam int MAX_DECODED = 1024;
	localparam int CNT_W       = $clog2(MAX_DECODED + 1);
	localparam int IDX_W       = 10;
	localparam int LEN_W       = 16;
	localparam int HDR_BYTES   = 4;
	// header plus trailing crc byte
	localparam int OVERHEAD    = HDR_BYTES + 1;
	localparam int CMP_W       = ((CNT_W > LEN_W + 1) ? CNT_W : LEN_W + 1) + 1;

	localparam logic [7:0] CRC_POLY = 8'h07;
	localparam logic [7:0] CODE_FULL = 8'hFF;
	localparam logic [7:0] CODE_ONE  = 8'h01;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_ZERO_CODE = 3'd1,
		ST_TRUNC     = 3'd2,
		ST_OVERFLOW  = 3'd3,
		ST_SHORT     = 3'd4,
		ST_LEN_BAD   = 3'd5,
		ST_CRC_BAD   = 3'd6
	} status_t;

	typedef struct packed {
		logic [7:0]       group_left;
		logic             group_full;
		logic             zero_pending;
		logic [CNT_W-1:0] cnt;
		logic [7:0]       held;
		logic [7:0]       crc;
		logic [7:0]       hdr_type;
		logic [7:0]       hdr_tag;
		logic [LEN_W-1:0] hdr_len;
		status_t          err;
	} state_t;

	typedef struct packed {
		logic             payload_valid;
		logic [7:0]       payload_byte;
		logic [IDX_W-1:0] payload_index;
		logic             frame_done;
		status_t          status;
		logic [7:0]       pkt_type;
		logic [7:0]       pkt_tag;
		logic [LEN_W-1:0] payload_len;
	} result_t;

	// msb-first crc-8, no reflection
	function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ===== design/ccpd_in_if.sv =====
// ----------------------------------------------------------------------------
// COBS CRC-8 deframer input channel
// Valid/ready channel carrying one encoded byte and its end-of-frame flag.
// ----------------------------------------------------------------------------
interface ccpd_in_if;

	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);

endinterface

// ===== design/ccpd_out_if.sv =====
// ----------------------------------------------------------------------------
// COBS CRC-8 deframer result channel
// Valid/ready channel carrying payload bytes and the frame status word.
// ----------------------------------------------------------------------------
interface ccpd_out_if;

	logic                       valid;
	logic                       ready;
	logic                       payload_valid;
	logic [7:0]                 payload_byte;
	logic [ccpd_pkg::IDX_W-1:0] payload_index;
	logic                       frame_done;
	logic [2:0]                 status;
	logic [7:0]                 pkt_type;
	logic [7:0]                 pkt_tag;
	logic [ccpd_pkg::LEN_W-1:0] payload_len;

	modport source (output valid, output payload_valid, output payload_byte,
		output payload_index, output frame_done, output status, output pkt_type,
		output pkt_tag, output payload_len, input ready);
	modport sink (input valid, input payload_valid, input payload_byte,
		input payload_index, input frame_done, input status, input pkt_type,
		input pkt_tag, input payload_len, output ready);

endinterface

// ===== design/cobs_crc8_packet_deframer_core.sv =====
// ----------------------------------------------------------------------------
// COBS CRC-8 packet deframer
// Decodes COBS bytes on the fly, splits header, checks length and CRC-8.
// ----------------------------------------------------------------------------
// Usage:
//   enc carries one COBS-encoded byte per word, delimiter removed, with
//   last_byte set on the final byte of a frame. dec carries results: a
//   tentative payload byte, and on the word for last_byte the frame status
//   and header (type, tag, little-endian length).
//   A byte is taken into an input register, decoded in one pass from there,
//   and its result lands in the output register once that register can
//   move. Payload bytes lag one decoded byte since the newest byte is held
//   for the crc compare. Bytes that produce no result leave nothing on dec.
//   Throughput is one word per cycle while dec does not stall; the decode
//   pass, byte-wide crc fold and group counter are all combinational.
//   When dec stalls, the output register holds its word and the input
//   register holds one more byte; enc.ready then drops until dec moves.
//   Reset clears the deframer state and both registers' valid flags; after
//   last_byte the state returns to its reset value by itself.
// ----------------------------------------------------------------------------
`include "cobs_crc8_packet_deframer_core_assert.svh"

module cobs_crc8_packet_deframer_core (
	input  logic       clk,
	input  logic       arst_n,
	ccpd_in_if.sink    enc,
	ccpd_out_if.source dec
);

	logic                       valid_s1;
	logic [7:0]                 data_s1;
	logic                       last_s1;
	ccpd_pkg::state_t           st_q;
	ccpd_pkg::state_t           upd;
	ccpd_pkg::state_t           st_n;
	ccpd_pkg::result_t          res;
	ccpd_pkg::result_t          out_q;
	logic                       out_valid_q;
	logic                       adv;
	logic                       absorb_en;
	logic [7:0]                 absorb_d;
	logic                       emit;
	logic                       produce;
	logic                       full;
	ccpd_pkg::status_t          status;
	logic [ccpd_pkg::CMP_W-1:0] want_cnt;

	assign adv       = !out_valid_q || dec.ready;
	assign enc.ready = !valid_s1 || adv;
	assign full      = st_q.cnt >= ccpd_pkg::CNT_W'(ccpd_pkg::MAX_DECODED);

	// cobs group tracking and decoded byte selection
	always_comb begin
		upd       = st_q;
		absorb_en = 1'b0;
		absorb_d  = '0;
		emit      = 1'b0;
		res       = '0;
		if (st_q.err == ccpd_pkg::ST_OK) begin
			if (st_q.group_left == '0) begin
				if (st_q.zero_pending) begin
					upd.zero_pending = 1'b0;
					if (full) begin
						upd.err = ccpd_pkg::ST_OVERFLOW;
					end else begin
						absorb_en = 1'b1;
					end
				end
				if (upd.err == ccpd_pkg::ST_OK) begin
					if (data_s1 == '0) begin
						upd.err = ccpd_pkg::ST_ZERO_CODE;
					end else begin
						upd.group_full = (data_s1 == ccpd_pkg::CODE_FULL);
						upd.group_left = data_s1 - 8'd1;
						if (data_s1 == ccpd_pkg::CODE_ONE) begin
							upd.zero_pending = 1'b1;
						end
					end
				end
			end else begin
				if (full) begin
					upd.err = ccpd_pkg::ST_OVERFLOW;
				end else begin
					absorb_en        = 1'b1;
					absorb_d         = data_s1;
					upd.group_left   = st_q.group_left - 8'd1;
					if (st_q.group_left == 8'd1) begin
						upd.zero_pending = !st_q.group_full;
					end
				end
			end
		end

		// header capture, crc over the held byte, release of the held byte
		if (absorb_en) begin
			case (st_q.cnt)
				ccpd_pkg::CNT_W'(0): upd.hdr_type = absorb_d;
				ccpd_pkg::CNT_W'(1): upd.hdr_tag = absorb_d;
				ccpd_pkg::CNT_W'(2): upd.hdr_len[7:0] = absorb_d;
				ccpd_pkg::CNT_W'(3): upd.hdr_len[15:8] = absorb_d;
				default: ;
			endcase
			if (st_q.cnt != '0) begin
				upd.crc = ccpd_pkg::crc_fold(st_q.crc, st_q.held);
			end
			if (st_q.cnt >= ccpd_pkg::CNT_W'(ccpd_pkg::OVERHEAD)) begin
				emit              = 1'b1;
				res.payload_byte  = st_q.held;
				res.payload_index = ccpd_pkg::IDX_W'(st_q.cnt -
					ccpd_pkg::CNT_W'(ccpd_pkg::OVERHEAD));
			end
			upd.held = absorb_d;
			upd.cnt  = st_q.cnt + ccpd_pkg::CNT_W'(1);
		end

		if (upd.err != ccpd_pkg::ST_OK) begin
			emit              = 1'b0;
			res.payload_byte  = '0;
			res.payload_index = '0;
		end

		want_cnt = ccpd_pkg::CMP_W'(upd.hdr_len) + ccpd_pkg::CMP_W'(ccpd_pkg::OVERHEAD);
		if (upd.err != ccpd_pkg::ST_OK) begin
			status = upd.err;
		end else if (upd.group_left != '0) begin
			status = ccpd_pkg::ST_TRUNC;
		end else if (upd.cnt < ccpd_pkg::CNT_W'(ccpd_pkg::OVERHEAD)) begin
			status = ccpd_pkg::ST_SHORT;
		end else if (ccpd_pkg::CMP_W'(upd.cnt) != want_cnt) begin
			status = ccpd_pkg::ST_LEN_BAD;
		end else if (upd.crc != upd.held) begin
			status = ccpd_pkg::ST_CRC_BAD;
		end else begin
			status = ccpd_pkg::ST_OK;
		end

		res.payload_valid = emit;
		res.frame_done    = last_s1;
		if (last_s1) begin
			res.status      = status;
			res.pkt_type    = upd.hdr_type;
			res.pkt_tag     = upd.hdr_tag;
			res.payload_len = upd.hdr_len;
		end
		produce = emit || last_s1;
		st_n    = last_s1 ? ccpd_pkg::state_t'('0) : upd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (enc.valid && enc.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (enc.valid && enc.ready) begin
			data_s1 <= enc.data_byte;
			last_s1 <= enc.last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (valid_s1 && adv) begin
			st_q <= st_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1 && produce;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1 && produce) begin
			out_q <= res;
		end
	end

	assign dec.valid         = out_valid_q;
	assign dec.payload_valid = out_q.payload_valid;
	assign dec.payload_byte  = out_q.payload_byte;
	assign dec.payload_index = out_q.payload_index;
	assign dec.frame_done    = out_q.frame_done;
	assign dec.status        = out_q.status;
	assign dec.pkt_type      = out_q.pkt_type;
	assign dec.pkt_tag       = out_q.pkt_tag;
	assign dec.payload_len   = out_q.payload_len;

	// a result word always carries a payload byte or a frame end
	`CCPD_ASSERT(a_result_nonempty, clk, arst_n,
		!out_valid_q || out_q.payload_valid || out_q.frame_done)
	// decoded count never runs past the buffer limit
	`CCPD_ASSERT(a_cnt_bound, clk, arst_n,
		st_q.cnt <= ccpd_pkg::CNT_W'(ccpd_pkg::MAX_DECODED))
	// a pending zero only exists between groups
	`CCPD_ASSERT(a_zero_between_groups, clk, arst_n,
		st_q.group_left == '0 || !st_q.zero_pending)
	// frame end returns the deframer to its idle state
	`CCPD_ASSERT_NEXT(a_frame_end_clears, clk, arst_n, valid_s1 && adv && last_s1,
		st_q.cnt == '0 && st_q.err == ccpd_pkg::ST_OK && st_q.group_left == '0)

endmodule

// ===== tb/sv/ccpd_tb_pkg.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// COBS CRC-8 deframer scoreboard
// Frame builders, COBS encoder and a scoreboard that decodes each accepted
// word on its own and checks the result channel against what it predicts.
// ----------------------------------------------------------------------------
package ccpd_tb_pkg;

	import ccpd_pkg::*;

	typedef logic [7:0] byte_q_t[$];

	// serial form: one feedback bit per data bit, msb first
	function automatic logic [7:0] crc8_shift(input logic [7:0] crc, input logic [7:0] d);
		logic [7:0] c;
		logic       fb;
		c = crc;
		for (int i = 7; i >= 0; i--) begin
			fb = c[7] ^ d[i];
			c = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
		end
		return c;
	endfunction

	// header, random payload and trailing crc, not yet encoded
	function automatic byte_q_t make_packet(input logic [7:0] ptype, input logic [7:0] ptag,
			input int n, input logic [15:0] hlen, input int zero_pct, input bit bad_crc);
		byte_q_t    raw;
		logic [7:0] crc;
		raw = '{ptype, ptag, hlen[7:0], hlen[15:8]};
		for (int i = 0; i < n; i++) begin
			raw.push_back(($urandom_range(99) < zero_pct) ? 8'h00 : 8'($urandom_range(1, 255)));
		end
		crc = 8'h00;
		foreach (raw[i]) begin
			crc = crc8_shift(crc, raw[i]);
		end
		if (bad_crc) begin
			crc ^= 8'($urandom_range(1, 255));
		end
		raw.push_back(crc);
		return raw;
	endfunction

	function automatic byte_q_t cobs_encode(input byte_q_t raw);
		byte_q_t    coded;
		int         code_pos;
		logic [7:0] code;
		coded.push_back(8'h00);
		code_pos = 0;
		code = CODE_ONE;
		foreach (raw[i]) begin
			if (raw[i] == 8'h00) begin
				coded[code_pos] = code;
				code_pos = coded.size();
				coded.push_back(8'h00);
				code = CODE_ONE;
			end else begin
				coded.push_back(raw[i]);
				code++;
				if (code == CODE_FULL) begin
					coded[code_pos] = code;
					code_pos = coded.size();
					coded.push_back(8'h00);
					code = CODE_ONE;
				end
			end
		end
		coded[code_pos] = code;
		return coded;
	endfunction

	class deframe_scoreboard;

		logic [7:0]  group_left;
		bit          group_full;
		bit          zero_pending;
		int unsigned n_decoded;
		logic [7:0]  held;
		logic [7:0]  crc;
		logic [7:0]  hdr_type;
		logic [7:0]  hdr_tag;
		logic [15:0] hdr_len;
		status_t     err;

		result_t     due_results[$];
		int          n_words;
		int          n_mismatch;

		function new();
			clear_state();
			n_words = 0;
			n_mismatch = 0;
		endfunction

		function void clear_state();
			group_left = 8'h00;
			group_full = 1'b0;
			zero_pending = 1'b0;
			n_decoded = 0;
			held = 8'h00;
			crc = 8'h00;
			hdr_type = 8'h00;
			hdr_tag = 8'h00;
			hdr_len = 16'h0000;
			err = ST_OK;
		endfunction

		function int pending();
			return due_results.size();
		endfunction

		// takes one decoded byte, releases the held one once past the header
		function bit take_byte(input logic [7:0] d, inout result_t r);
			bit rel;
			rel = 1'b0;
			case (n_decoded)
				0: hdr_type = d;
				1: hdr_tag = d;
				2: hdr_len[7:0] = d;
				3: hdr_len[15:8] = d;
				default: ;
			endcase
			if (n_decoded >= 1) begin
				crc = crc8_shift(crc, held);
				if (n_decoded >= OVERHEAD) begin
					rel = 1'b1;
					r.payload_byte = held;
					r.payload_index = IDX_W'(n_decoded - OVERHEAD);
				end
			end
			held = d;
			n_decoded++;
			return rel;
		endfunction

		// returns 1 unless the word is dropped behind a sticky error
		function bit decode_word(input logic [7:0] b, input logic last);
			result_t r;
			bit      emit;
			bit      live;
			r = '0;
			emit = 1'b0;
			live = (err == ST_OK) || last;
			if (err == ST_OK) begin
				if (group_left == 8'h00) begin
					if (zero_pending) begin
						zero_pending = 1'b0;
						if (n_decoded >= MAX_DECODED) begin
							err = ST_OVERFLOW;
						end else begin
							emit = take_byte(8'h00, r);
						end
					end
					if (err == ST_OK) begin
						if (b == 8'h00) begin
							err = ST_ZERO_CODE;
						end else begin
							group_full = (b == CODE_FULL);
							group_left = b - 8'd1;
							if (group_left == 8'h00) begin
								zero_pending = !group_full;
							end
						end
					end
				end else if (n_decoded >= MAX_DECODED) begin
					err = ST_OVERFLOW;
				end else begin
					emit = take_byte(b, r);
					group_left--;
					if (group_left == 8'h00) begin
						zero_pending = !group_full;
					end
				end
			end
			if (err != ST_OK) begin
				emit = 1'b0;
			end
			r.payload_valid = emit;
			if (!emit) begin
				r.payload_byte = 8'h00;
				r.payload_index = '0;
			end
			if (last) begin
				r.frame_done = 1'b1;
				if (err != ST_OK) begin
					r.status = err;
				end else if (group_left != 8'h00) begin
					r.status = ST_TRUNC;
				end else if (n_decoded < OVERHEAD) begin
					r.status = ST_SHORT;
				end else if (n_decoded != OVERHEAD + hdr_len) begin
					r.status = ST_LEN_BAD;
				end else if (crc != held) begin
					r.status = ST_CRC_BAD;
				end else begin
					r.status = ST_OK;
				end
				r.pkt_type = hdr_type;
				r.pkt_tag = hdr_tag;
				r.payload_len = hdr_len;
				clear_state();
			end
			if (emit || last) begin
				due_results.push_back(r);
			end
			return live;
		endfunction

		task report(input string msg);
			$display("deframe check failed: %s", msg);
			n_mismatch++;
		endtask

		task cmp_field(input string name, input logic [15:0] got, input logic [15:0] want);
			if (got !== want) begin
				report($sformatf("word %0d %s: got %0h, want %0h", n_words, name, got, want));
			end
		endtask

		task check_result(input result_t got);
			result_t want;
			n_words++;
			if (due_results.size() == 0) begin
				report($sformatf("word %0d arrived with nothing due", n_words));
				return;
			end
			want = due_results.pop_front();
			cmp_field("payload_valid", got.payload_valid, want.payload_valid);
			cmp_field("payload_byte", got.payload_byte, want.payload_byte);
			cmp_field("payload_index", got.payload_index, want.payload_index);
			cmp_field("frame_done", got.frame_done, want.frame_done);
			cmp_field("status", got.status, want.status);
			cmp_field("pkt_type", got.pkt_type, want.pkt_type);
			cmp_field("pkt_tag", got.pkt_tag, want.pkt_tag);
			cmp_field("payload_len", got.payload_len, want.payload_len);
		endtask

	endclass

endpackage

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// COBS CRC-8 deframer testbench
// Sends directed and random COBS frames, good and broken, under shifting
// sender and receiver stalls, and checks every result word in order.
// ----------------------------------------------------------------------------
module tb;

	import ccpd_pkg::*;
	import ccpd_tb_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 4;
	localparam int PHASE_ITEMS    = 100;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	ccpd_in_if  enc ();
	ccpd_out_if dec ();

	cobs_crc8_packet_deframer_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.enc    (enc),
		.dec    (dec)
	);

	deframe_scoreboard sb = new();

	int      send_idle = 28;
	int      recv_idle = 87;
	int      live_count = 0;
	int      quiet_cycles = 0;
	logic    in_fire = 1'b0;
	logic    out_fire = 1'b0;
	result_t dec_word;

	always #10 clk = ~clk;

	// handshakes are sampled mid-cycle and take effect at the next rising edge
	always @(negedge clk) begin
		in_fire = (enc.valid === 1'b1) && (enc.ready === 1'b1);
		out_fire = (dec.valid === 1'b1) && (dec.ready === 1'b1);
		dec_word.payload_valid = dec.payload_valid;
		dec_word.payload_byte = dec.payload_byte;
		dec_word.payload_index = dec.payload_index;
		dec_word.frame_done = dec.frame_done;
		dec_word.status = status_t'(dec.status);
		dec_word.pkt_type = dec.pkt_type;
		dec_word.pkt_tag = dec.pkt_tag;
		dec_word.payload_len = dec.payload_len;
	end

	always @(posedge clk) begin
		if (in_fire || out_fire) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("cobs_crc8_packet_deframer_core: mismatch");
			$finish;
		end
	end

	initial begin
		dec.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_fire) begin
				sb.check_result(dec_word);
			end
			dec.ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	task automatic send_word(input logic [7:0] b, input logic last);
		while ($urandom_range(99) < send_idle) begin
			enc.valid <= 1'b0;
			enc.data_byte <= 8'($urandom);
			enc.last_byte <= 1'($urandom);
			@(posedge clk);
		end
		enc.valid <= 1'b1;
		enc.data_byte <= b;
		enc.last_byte <= last;
		do @(posedge clk); while (!in_fire);
		if (sb.decode_word(b, last)) begin
			live_count++;
		end
	endtask

	task automatic send_frame(input byte_q_t coded);
		foreach (coded[i]) begin
			send_word(coded[i], i == coded.size() - 1);
		end
	endtask

	// stop sending until the result channel has caught up
	task automatic wait_drained();
		enc.valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	task automatic random_frame();
		byte_q_t     raw;
		byte_q_t     coded;
		int          kind;
		int          n;
		int          zp;
		logic [15:0] hlen;
		kind = $urandom_range(99);
		zp = $urandom_range(0, 40);
		n = ($urandom_range(19) == 0) ? $urandom_range(250, 300) : $urandom_range(0, 24);
		// long nonzero runs give full 0xff groups
		if (n >= 250) begin
			zp = $urandom_range(0, 1);
		end
		hlen = 16'(n);
		if (kind >= 60 && kind < 68) begin
			case ($urandom_range(2))
				0: hlen = 16'(n + 1);
				1: hlen = 16'(n - 1);
				default: hlen = 16'($urandom);
			endcase
		end
		raw = make_packet(8'($urandom), 8'($urandom), n, hlen, zp, kind >= 68 && kind < 78);
		coded = cobs_encode(raw);
		if (kind >= 78 && kind < 86) begin
			if (coded.size() > 1) begin
				repeat ($urandom_range(1, (coded.size() > 3) ? 3 : coded.size() - 1)) begin
					void'(coded.pop_back());
				end
			end
		end else if (kind >= 86 && kind < 92) begin
			if ($urandom_range(1)) begin
				coded.insert($urandom_range(0, coded.size() - 1), 8'h00);
			end else begin
				coded[$urandom_range(0, coded.size() - 1)] = 8'($urandom);
			end
		end else if (kind >= 92 && kind < 96) begin
			raw.delete();
			repeat ($urandom_range(0, 4)) begin
				raw.push_back(($urandom_range(3) == 0) ? 8'h00 : 8'($urandom));
			end
			coded = cobs_encode(raw);
		end else if (kind >= 96) begin
			coded.delete();
			repeat ($urandom_range(1, 12)) begin
				coded.push_back(8'($urandom));
			end
		end
		send_frame(coded);
	endtask

	task automatic run_random(input int target);
		int start;
		start = live_count;
		while (live_count - start < target) begin
			random_frame();
		end
	endtask

	initial begin
		byte_q_t frame;
		enc.valid <= 1'b0;
		enc.data_byte <= 8'h00;
		enc.last_byte <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// lone code byte, nothing decoded
		frame = '{8'h01};
		send_frame(frame);
		frame = '{8'h00};
		send_frame(frame);
		// zero code after a pending zero, then ignored bytes
		frame = '{8'h02, 8'hFF, 8'h00, 8'h05};
		send_frame(frame);
		// frame ends inside a group
		frame = '{8'h05, 8'h11, 8'h22};
		send_frame(frame);
		send_frame(cobs_encode(make_packet(8'hFF, 8'h00, 0, 16'd0, 0, 1'b0)));
		send_frame(cobs_encode(make_packet(8'h00, 8'hFF, 0, 16'd0, 0, 1'b1)));
		send_frame(cobs_encode(make_packet(8'h5A, 8'hA5, 1, 16'd2, 50, 1'b0)));

		run_random(PHASE_ITEMS);
		wait_drained();

		send_idle = 87;
		recv_idle = 28;
		// one decoded byte past the limit
		send_frame(cobs_encode(make_packet(8'($urandom), 8'($urandom), MAX_DECODED - 4,
			16'(MAX_DECODED - 4), 20, 1'b0)));
		run_random(PHASE_ITEMS);
		wait_drained();

		send_idle = 0;
		recv_idle = 0;
		run_random(PHASE_ITEMS);

		enc.valid <= 1'b0;
		while (sb.pending() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.n_mismatch == 0 && sb.pending() == 0) begin
			$display("cobs_crc8_packet_deframer_core: match");
		end else begin
			$display("cobs_crc8_packet_deframer_core: mismatch");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+design
design/ccpd_pkg.sv
design/ccpd_in_if.sv
design/ccpd_out_if.sv
design/cobs_crc8_packet_deframer_core.sv
tb/sv/ccpd_tb_pkg.sv
tb/sv/tb.sv
